// ----- sv/sipi_pkg.sv -----
// sipi_pkg: widths, saturation limits and the geometry-to-divider bundle
// for the segment intersection pipeline. No dependencies.
package sipi_pkg;

  localparam int CW     = 16;  // coordinate width, signed
  localparam int EW     = 8;   // epsilon width
  localparam int OW     = 24;  // output point width, signed
  localparam int DENW   = 35;  // divider denominator 2*|det|
  localparam int RW     = 61;  // divider remainder width
  localparam int QW     = 24;  // quotient bits produced
  localparam int RND_SH = 9;   // numerator scale: 8 output guard bits plus rounding bit

  localparam int GEO_STAGES = 6;
  localparam int DIV_STAGES = QW + 1;
  localparam int NST        = GEO_STAGES + DIV_STAGES + 1;

  localparam logic [OW-1:0] SAT_MAG = 24'h800000;
  localparam logic [OW-1:0] SAT_POS = 24'h7FFFFF;

  // one beat leaving the geometry section toward the dividers
  typedef struct packed {
    logic            hit;
    logic            touch;
    logic            neg_x;
    logic            neg_y;
    logic [RW-1:0]   num_x;
    logic [RW-1:0]   num_y;
    logic [DENW-1:0] den;
  } geo_t;

endpackage

// ----- sv/sipi_geom.sv -----
// sipi_geom: six-stage geometry section: closeness tests, orientation tests,
// determinant and numerators, magnitude/sign split. Uses sipi_pkg.
module sipi_geom #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                   clk,
  input  logic [sipi_pkg::GEO_STAGES-1:0]        en,
  input  logic [8*sipi_pkg::CW-1:0]              crd_i,
  input  logic [sipi_pkg::EW-1:0]                eps_i,
  output sipi_pkg::geo_t                         geo_o
);

  localparam int LIMW = sipi_pkg::EW + FRAC_BITS;

  // stage 1: raw coordinates and differences
  logic signed [15:0] crd1_r [8];
  logic signed [16:0] sdx1_r [4], sdy1_r [4], rx1_r [4], ry1_r [4], sx1_r [4], sy1_r [4];
  logic signed [16:0] pdx1_r, pdy1_r, qdx1_r, qdy1_r;
  logic [7:0]         e1_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 8; i++) crd1_r[i] <= crd_i[16*i +: 16];
      for (int k = 0; k < 4; k++) begin
        // near test k: point P against segment A-B
        sdx1_r[k] <= 17'($signed(crd_i[16*(2*((k<2)?1:3)) +: 16]))
                   - 17'($signed(crd_i[16*(2*((k<2)?0:2)) +: 16]));
        sdy1_r[k] <= 17'($signed(crd_i[16*(2*((k<2)?1:3)+1) +: 16]))
                   - 17'($signed(crd_i[16*(2*((k<2)?0:2)+1) +: 16]));
        rx1_r[k]  <= 17'($signed(crd_i[16*(2*((k<2)?(2+k):(k-2))) +: 16]))
                   - 17'($signed(crd_i[16*(2*((k<2)?0:2)) +: 16]));
        ry1_r[k]  <= 17'($signed(crd_i[16*(2*((k<2)?(2+k):(k-2))+1) +: 16]))
                   - 17'($signed(crd_i[16*(2*((k<2)?0:2)+1) +: 16]));
        sx1_r[k]  <= 17'($signed(crd_i[16*(2*((k<2)?(2+k):(k-2))) +: 16]))
                   - 17'($signed(crd_i[16*(2*((k<2)?1:3)) +: 16]));
        sy1_r[k]  <= 17'($signed(crd_i[16*(2*((k<2)?(2+k):(k-2))+1) +: 16]))
                   - 17'($signed(crd_i[16*(2*((k<2)?1:3)+1) +: 16]));
      end
      pdx1_r <= 17'($signed(crd_i[0 +: 16]))  - 17'($signed(crd_i[32 +: 16]));
      pdy1_r <= 17'($signed(crd_i[16 +: 16])) - 17'($signed(crd_i[48 +: 16]));
      qdx1_r <= 17'($signed(crd_i[64 +: 16])) - 17'($signed(crd_i[96 +: 16]));
      qdy1_r <= 17'($signed(crd_i[80 +: 16])) - 17'($signed(crd_i[112 +: 16]));
      e1_r   <= eps_i;
    end
  end

  // stage 2: all products
  logic signed [33:0] mx2_r [4], my2_r [4], rrx2_r [4], rry2_r [4], ssx2_r [4], ssy2_r [4];
  logic signed [33:0] dn1_r [4], dn2_r [4], cp1_r [4], cp2_r [4];
  logic signed [33:0] dp1_r, dp2_r;
  logic signed [31:0] fa_r, fb_r, fc_r, fd_r;
  logic signed [16:0] pdx2_r, pdy2_r, qdx2_r, qdy2_r;
  logic [15:0]        e22_r;
  logic [7:0]         e2_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 4; k++) begin
        mx2_r[k]  <= sdx1_r[k] * sdx1_r[k];
        my2_r[k]  <= sdy1_r[k] * sdy1_r[k];
        rrx2_r[k] <= rx1_r[k] * rx1_r[k];
        rry2_r[k] <= ry1_r[k] * ry1_r[k];
        ssx2_r[k] <= sx1_r[k] * sx1_r[k];
        ssy2_r[k] <= sy1_r[k] * sy1_r[k];
        dn1_r[k]  <= rx1_r[k] * sdx1_r[k];
        dn2_r[k]  <= ry1_r[k] * sdy1_r[k];
        cp1_r[k]  <= rx1_r[k] * sdy1_r[k];
        cp2_r[k]  <= ry1_r[k] * sdx1_r[k];
      end
      dp1_r  <= pdx1_r * qdy1_r;
      dp2_r  <= pdy1_r * qdx1_r;
      fa_r   <= crd1_r[0] * crd1_r[3];
      fb_r   <= crd1_r[1] * crd1_r[2];
      fc_r   <= crd1_r[4] * crd1_r[7];
      fd_r   <= crd1_r[5] * crd1_r[6];
      pdx2_r <= pdx1_r;
      pdy2_r <= pdy1_r;
      qdx2_r <= qdx1_r;
      qdy2_r <= qdy1_r;
      e22_r  <= e1_r * e1_r;
      e2_r   <= e1_r;
    end
  end

  // stage 3: sums (squared lengths, dot and cross products, det, f terms)
  logic [32:0]        m3_r [4], rr3_r [4], ss3_r [4];
  logic signed [33:0] n3_r [4], cr3_r [4];
  logic signed [33:0] det3_r;
  logic signed [32:0] f13_r, f23_r;
  logic signed [16:0] pdx3_r, pdy3_r, qdx3_r, qdy3_r;
  logic [15:0]        e23_r;
  logic [7:0]         e3_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < 4; k++) begin
        m3_r[k]  <= {1'b0, mx2_r[k][31:0]} + {1'b0, my2_r[k][31:0]};
        rr3_r[k] <= {1'b0, rrx2_r[k][31:0]} + {1'b0, rry2_r[k][31:0]};
        ss3_r[k] <= {1'b0, ssx2_r[k][31:0]} + {1'b0, ssy2_r[k][31:0]};
        n3_r[k]  <= dn1_r[k] + dn2_r[k];
        cr3_r[k] <= cp1_r[k] - cp2_r[k];
      end
      det3_r <= dp1_r - dp2_r;
      f13_r  <= 33'(fa_r) - 33'(fb_r);
      f23_r  <= 33'(fc_r) - 33'(fd_r);
      pdx3_r <= pdx2_r;
      pdy3_r <= pdy2_r;
      qdx3_r <= qdx2_r;
      qdy3_r <= qdy2_r;
      e23_r  <= e22_r;
      e3_r   <= e2_r;
    end
  end

  // stage 4: compares, cross-term squares, numerator products
  logic [33:0]        ac4 [4];
  logic [33:0]        adet4;
  logic [LIMW-1:0]    lim4;
  logic               deg4_r [4], nle4_r [4], nge4_r [4], na4_r [4], nb4_r [4];
  logic               lft4_r [4], big4_r [4];
  logic [51:0]        acsq4_r [4];
  logic [48:0]        em4_r [4];
  logic               pok4_r;
  logic signed [33:0] det4_r;
  logic signed [49:0] x14_r, x24_r, y14_r, y24_r;

  always_comb begin
    for (int k = 0; k < 4; k++) ac4[k] = cr3_r[k][33] ? 34'(-cr3_r[k]) : 34'(cr3_r[k]);
    adet4 = det3_r[33] ? 34'(-det3_r) : 34'(det3_r);
    lim4  = {e3_r, {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < 4; k++) begin
        deg4_r[k]  <= (m3_r[k] == '0) || (m3_r[k] < {17'd0, e23_r});
        nle4_r[k]  <= (n3_r[k] <= 34'sd0);
        nge4_r[k]  <= (n3_r[k] >= $signed({1'b0, m3_r[k]}));
        na4_r[k]   <= (rr3_r[k] < {17'd0, e23_r});
        nb4_r[k]   <= (ss3_r[k] < {17'd0, e23_r});
        lft4_r[k]  <= cr3_r[k][33];  // cross3 of the orientation test is -cr
        big4_r[k]  <= |ac4[k][33:26];
        acsq4_r[k] <= ac4[k][25:0] * ac4[k][25:0];
        em4_r[k]   <= e23_r * m3_r[k];
      end
      pok4_r <= (det3_r != '0) && (adet4 >= 34'(lim4));
      det4_r <= det3_r;
      x14_r  <= f13_r * qdx3_r;
      x24_r  <= f23_r * pdx3_r;
      y14_r  <= f13_r * qdy3_r;
      y24_r  <= f23_r * pdy3_r;
    end
  end

  // stage 5: touch, straddle, numerators
  logic               near5 [4];
  logic               touch5_r, hit5_r;
  logic signed [50:0] nx5_r, ny5_r;
  logic signed [33:0] det5_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (deg4_r[k] || nle4_r[k]) near5[k] = na4_r[k];
      else if (nge4_r[k])         near5[k] = nb4_r[k];
      else                        near5[k] = !big4_r[k] && (acsq4_r[k] < {3'd0, em4_r[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      touch5_r <= near5[0] | near5[1] | near5[2] | near5[3];
      hit5_r   <= (near5[0] | near5[1] | near5[2] | near5[3] |
                   ((lft4_r[0] != lft4_r[1]) && (lft4_r[2] != lft4_r[3]))) && pok4_r;
      nx5_r    <= 51'(x14_r) - 51'(x24_r);
      ny5_r    <= 51'(y14_r) - 51'(y24_r);
      det5_r   <= det4_r;
    end
  end

  // stage 6: magnitudes, rounding offset, signs
  logic [50:0] anx6, any6;
  logic [33:0] ad6;
  sipi_pkg::geo_t geo_r;

  always_comb begin
    anx6 = nx5_r[50] ? 51'(-nx5_r) : 51'(nx5_r);
    any6 = ny5_r[50] ? 51'(-ny5_r) : 51'(ny5_r);
    ad6  = det5_r[33] ? 34'(-det5_r) : 34'(det5_r);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      geo_r.hit   <= hit5_r;
      geo_r.touch <= touch5_r;
      geo_r.neg_x <= nx5_r[50] != det5_r[33];
      geo_r.neg_y <= ny5_r[50] != det5_r[33];
      geo_r.num_x <= {1'b0, anx6, {sipi_pkg::RND_SH{1'b0}}} + sipi_pkg::RW'(ad6);
      geo_r.num_y <= {1'b0, any6, {sipi_pkg::RND_SH{1'b0}}} + sipi_pkg::RW'(ad6);
      geo_r.den   <= {ad6, 1'b0};
    end
  end

  assign geo_o = geo_r;

endmodule

// ----- sv/sipi_div.sv -----
// sipi_div: restoring divider, one quotient bit per stage, with saturation
// and sign applied at the end. Uses sipi_pkg.
module sipi_div (
  input  logic                              clk,
  input  logic [sipi_pkg::DIV_STAGES-1:0]   en,
  input  logic [sipi_pkg::RW-1:0]           num_i,
  input  logic [sipi_pkg::DENW-1:0]         den_i,
  input  logic                              neg_i,
  output logic signed [sipi_pkg::OW-1:0]    res_o
);

  localparam int RW = sipi_pkg::RW;
  localparam int QW = sipi_pkg::QW;
  localparam int NS = sipi_pkg::DIV_STAGES;

  logic [RW-1:0]              rem_r [NS];
  logic [QW-1:0]              q_r   [NS];
  logic [sipi_pkg::DENW-1:0]  den_r [NS];
  logic                       neg_r [NS];
  logic                       ovf_r [NS];

  // stage 0: quotient beyond QW bits saturates
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0] <= num_i;
      q_r[0]   <= '0;
      den_r[0] <= den_i;
      neg_r[0] <= neg_i;
      ovf_r[0] <= num_i >= RW'({den_i, {QW{1'b0}}});
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 1; j < NS; j++) begin : g_step
    logic [RW:0] t;
    assign t = {1'b0, rem_r[j-1]} - ((RW+1)'(den_r[j-1]) << (QW - j));
    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_r[j] <= t[RW] ? rem_r[j-1] : t[RW-1:0];
        q_r[j]   <= {q_r[j-1][QW-2:0], !t[RW]};
        den_r[j] <= den_r[j-1];
        neg_r[j] <= neg_r[j-1];
        ovf_r[j] <= ovf_r[j-1];
      end
    end
  end

  // clamp magnitude, then apply sign
  logic [QW-1:0] mag;
  always_comb begin
    if (ovf_r[NS-1] || q_r[NS-1] > sipi_pkg::SAT_MAG) mag = sipi_pkg::SAT_MAG;
    else                                               mag = q_r[NS-1];
    if (neg_r[NS-1])                  res_o = $signed(-mag);
    else if (mag == sipi_pkg::SAT_MAG) res_o = $signed(sipi_pkg::SAT_POS);
    else                              res_o = $signed(mag);
  end

endmodule

// ----- sv/segment_intersection_point_top.sv -----
// segment_intersection_point_top: pipelined segment intersection test with
// meeting point. Uses sipi_pkg, sipi_geom and sipi_div.
//
// Usage:
//   in_*  : one beat per segment pair. in_tdata holds, from bit 0 up,
//           first_start_x/y, first_end_x/y, second_start_x/y, second_end_x/y,
//           each signed 16-bit Q8.8.
//   out_* : one beat per input beat, same order. out_tdata holds point_x then
//           point_y (signed Q8.16, saturated, zero when no hit); out_tuser
//           holds hit (bit 0) and touching (bit 1).
//   cfg_* : epsilon (8 bits), always ready; write only while the pipe is empty.
// The path from input beat to output beat runs through six geometry stages,
// a 25-stage divider (overflow check plus one quotient bit per stage) and the
// output register. Throughput is one pair per cycle while the receiver does
// not stall; the divider stage chain sets the depth.
// Reset clears all stage valid bits and sets epsilon to 1. When the receiver
// stalls, the result holds in the output register, and earlier stages keep
// accepting beats until every stage is full; then in_tready drops.
module segment_intersection_point_top #(
  parameter int FRAC_BITS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // fsx, fsy, fex, fey, ssx, ssy, sex, sey
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [47:0]  out_tdata,  // point_x, point_y
  output logic [1:0]   out_tuser,  // hit, touching
  input  logic         cfg_tvalid,
  output logic         cfg_tready,
  input  logic [7:0]   cfg_tdata   // epsilon
);

  localparam int NST = sipi_pkg::NST;
  localparam int G   = sipi_pkg::GEO_STAGES;
  localparam int NDV = sipi_pkg::DIV_STAGES;

  // epsilon register
  logic [7:0] eps_r;
  assign cfg_tready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n)          eps_r <= 8'd1;
    else if (cfg_tvalid) eps_r <= cfg_tdata;
  end

  // stage valids and bubble-collapsing enables
  logic [NST-1:0] v_r;
  logic [NST-1:0] en;
  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_tready;
    for (int i = NST - 2; i >= 0; i--) en[i] = !v_r[i] || en[i+1];
  end
  assign in_tready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_tvalid;
      for (int i = 1; i < NST; i++) if (en[i]) v_r[i] <= v_r[i-1];
    end
  end

  // geometry section
  sipi_pkg::geo_t geo;
  sipi_geom #(.FRAC_BITS(FRAC_BITS)) u_geom (
    .clk   (clk),
    .en    (en[G-1:0]),
    .crd_i (in_tdata),
    .eps_i (eps_r),
    .geo_o (geo)
  );

  // dividers for x and y
  logic signed [23:0] res_x, res_y;
  sipi_div u_div_x (
    .clk   (clk),
    .en    (en[G+NDV-1:G]),
    .num_i (geo.num_x),
    .den_i (geo.den),
    .neg_i (geo.neg_x),
    .res_o (res_x)
  );
  sipi_div u_div_y (
    .clk   (clk),
    .en    (en[G+NDV-1:G]),
    .num_i (geo.num_y),
    .den_i (geo.den),
    .neg_i (geo.neg_y),
    .res_o (res_y)
  );

  // flags ride alongside the divider stages
  logic hit_r [NDV];
  logic tch_r [NDV];
  always_ff @(posedge clk) begin
    if (en[G]) begin
      hit_r[0] <= geo.hit;
      tch_r[0] <= geo.touch;
    end
    for (int j = 1; j < NDV; j++) begin
      if (en[G+j]) begin
        hit_r[j] <= hit_r[j-1];
        tch_r[j] <= tch_r[j-1];
      end
    end
  end

  // output register
  logic [47:0] odata_r;
  logic [1:0]  ouser_r;
  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      odata_r <= hit_r[NDV-1] ? {res_y, res_x} : 48'd0;
      ouser_r <= {tch_r[NDV-1], hit_r[NDV-1]};
    end
  end

  assign out_tvalid = v_r[NST-1];
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

  // no hit means a zero point
  a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 48'd0)
    else $error("point nonzero without hit");

  // any empty stage lets a beat in
  a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    !(&v_r) |-> in_tready)
    else $error("input stalled with an empty stage");

  // accepted beat occupies the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_r[0])
    else $error("accepted beat lost at entry");

  // a held result keeps its valid
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NST-1] && !out_tready |=> v_r[NST-1] && $stable(odata_r))
    else $error("stalled result changed");

endmodule
